// ===== src/fcl_pkg.sv =====
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared constants, codes and types of the int8 fully connected layer.
// ----------------------------------------------------------------------------
`default_nettype none

package fcl_pkg;

  localparam int MaxChannels = 64;
  localparam int MaxGroups   = 64;
  localparam int Positions   = 4 * MaxGroups;

  localparam int ChanW   = $clog2(MaxChannels);
  localparam int PosW    = $clog2(Positions);
  localparam int WAddrW  = ChanW + PosW;
  localparam int CntW    = $clog2(Positions + 1);
  localparam int ChCntW  = $clog2(MaxChannels + 1);
  localparam int RqShift = 30;

  typedef enum logic [1:0] {
    ReqAct    = 2'd0,
    ReqWeight = 2'd1,
    ReqBias   = 2'd2,
    ReqStart  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CfgGroups   = 2'd0,
    CfgChannels = 2'd1,
    CfgRelu     = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    StIdle,
    StBias,
    StMac,
    StDrain,
    StMul,
    StEmit
  } state_e;

  typedef struct packed {
    logic bias_ld;
    logic mac_en;
    logic mul_en;
  } mac_ctl_t;

  typedef struct packed {
    logic             emit;
    logic [ChanW-1:0] ch;
    logic             last;
  } emit_t;

  // Q30 rescale (arithmetic shift, low 32 bits) and int8 clip.
  function automatic logic signed [7:0] requant_clip(input logic signed [63:0] prod,
                                                     input logic relu);
    logic signed [31:0] r;
    logic signed [7:0]  res;
    r = $signed(prod[RqShift+31:RqShift]);
    if (relu) begin
      if (r < 32'sd0) begin
        res = 8'sd0;
      end else if (r > 32'sd127) begin
        res = 8'sd127;
      end else begin
        res = r[7:0];
      end
    end else begin
      if (r > 32'sd127) begin
        res = 8'sd127;
      end else if (r < -32'sd128) begin
        res = -8'sd128;
      end else begin
        res = r[7:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/fcl_req_if.sv =====
// ----------------------------------------------------------------------------
// fcl_req_if
// Request channel: loads of activations, weights, bias/multiplier, and start.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcl_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [5:0]         channel;
  logic [7:0]         position;
  logic signed [7:0]  activation;
  logic signed [15:0] weight;
  logic signed [31:0] bias;
  logic signed [31:0] multiplier;

  modport source (
    output valid, req_type, channel, position, activation, weight, bias, multiplier,
    input  ready
  );
  modport sink (
    input  valid, req_type, channel, position, activation, weight, bias, multiplier,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/fcl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fcl_rsp_if
// Result channel: one transfer per output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcl_rsp_if;
  logic              valid;
  logic              ready;
  logic [5:0]        out_channel;
  logic signed [7:0] out_value;
  logic              last;

  modport source (
    output valid, out_channel, out_value, last,
    input  ready
  );
  modport sink (
    input  valid, out_channel, out_value, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/fcl_store.sv =====
// ----------------------------------------------------------------------------
// fcl_store
// Activation, weight and bias/multiplier memories, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_store (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire fcl_pkg::req_e              wr_type_i,
  input  wire logic [fcl_pkg::ChanW-1:0]  wr_ch_i,
  input  wire logic [fcl_pkg::PosW-1:0]   wr_pos_i,
  input  wire logic signed [7:0]          act_i,
  input  wire logic signed [15:0]         weight_i,
  input  wire logic signed [31:0]         bias_i,
  input  wire logic signed [31:0]         mult_i,
  input  wire logic [fcl_pkg::ChanW-1:0]  rd_ch_i,
  input  wire logic [fcl_pkg::PosW-1:0]   rd_pos_i,
  output logic signed [7:0]               act_o,
  output logic signed [15:0]              weight_o,
  output logic signed [31:0]              bias_o,
  output logic signed [31:0]              mult_o
);

  logic [7:0]  act_mem [fcl_pkg::Positions];
  logic [15:0] w_mem   [fcl_pkg::MaxChannels * fcl_pkg::Positions];
  logic [63:0] bm_mem  [fcl_pkg::MaxChannels];

  logic [7:0]  act_q;
  logic [15:0] w_q;
  logic [63:0] bm_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_type_i == fcl_pkg::ReqAct)) begin
      act_mem[wr_pos_i] <= act_i;
    end
    act_q <= act_mem[rd_pos_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_type_i == fcl_pkg::ReqWeight)) begin
      w_mem[{wr_ch_i, wr_pos_i}] <= weight_i;
    end
    w_q <= w_mem[{rd_ch_i, rd_pos_i}];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_type_i == fcl_pkg::ReqBias)) begin
      bm_mem[wr_ch_i] <= {bias_i, mult_i};
    end
    bm_q <= bm_mem[rd_ch_i];
  end

  assign act_o    = $signed(act_q);
  assign weight_o = $signed(w_q);
  assign bias_o   = $signed(bm_q[63:32]);
  assign mult_o   = $signed(bm_q[31:0]);

endmodule

`default_nettype wire

// ===== src/fcl_mac.sv =====
// ----------------------------------------------------------------------------
// fcl_mac
// Product register, 32-bit wrapping accumulator, requant multiply and clip.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_mac (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fcl_pkg::mac_ctl_t  ctl_i,
  input  wire logic               relu_i,
  input  wire logic signed [7:0]  act_i,
  input  wire logic signed [15:0] weight_i,
  input  wire logic signed [31:0] bias_i,
  input  wire logic signed [31:0] mult_i,
  output logic signed [7:0]       value_o
);

  logic               mac_v1_q;
  logic               bias_v1_q;
  logic               prod_v_q;
  logic signed [23:0] prod_d;
  logic signed [23:0] prod_q;
  logic signed [31:0] acc_d;
  logic signed [31:0] acc_q;
  logic signed [31:0] mult_q;
  logic signed [63:0] prod64_d;
  logic signed [63:0] prod64_q;

  assign prod_d   = act_i * weight_i;
  assign prod64_d = acc_q * mult_q;

  always_comb begin
    acc_d = acc_q;
    if (bias_v1_q) begin
      acc_d = bias_i;
    end else if (prod_v_q) begin
      acc_d = acc_q + {{8{prod_q[23]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_v1_q  <= 1'b0;
      bias_v1_q <= 1'b0;
      prod_v_q  <= 1'b0;
      acc_q     <= '0;
    end else begin
      mac_v1_q  <= ctl_i.mac_en;
      bias_v1_q <= ctl_i.bias_ld;
      prod_v_q  <= mac_v1_q;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_v1_q) begin
      prod_q <= prod_d;
    end
    if (bias_v1_q) begin
      mult_q <= mult_i;
    end
    if (ctl_i.mul_en) begin
      prod64_q <= prod64_d;
    end
  end

  assign value_o = fcl_pkg::requant_clip(prod64_q, relu_i);

endmodule

`default_nettype wire

// ===== src/fcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcl_ctrl
// Run sequencer: walks channels and positions, drains the MAC, emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module fcl_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [6:0]                groups_i,
  input  wire logic [6:0]                chans_i,
  input  wire logic                      out_free_i,
  output logic                           idle_o,
  output logic [fcl_pkg::ChanW-1:0]      rd_ch_o,
  output logic [fcl_pkg::PosW-1:0]       rd_pos_o,
  output fcl_pkg::mac_ctl_t              ctl_o,
  output fcl_pkg::emit_t                 emit_o
);

  fcl_pkg::state_e                state_q, state_d;
  logic [fcl_pkg::ChanW-1:0]      ch_q, ch_d;
  logic [fcl_pkg::PosW-1:0]       pos_q, pos_d;
  logic                           drain_q, drain_d;
  logic [fcl_pkg::CntW-1:0]       npos;
  logic [fcl_pkg::ChCntW-1:0]     nch;
  logic                           last_pos;
  logic                           last_ch;

  assign npos = (32'(groups_i) > fcl_pkg::MaxGroups) ? fcl_pkg::CntW'(fcl_pkg::Positions)
                                                     : fcl_pkg::CntW'(32'(groups_i) * 4);
  assign nch  = (32'(chans_i) > fcl_pkg::MaxChannels) ?
                fcl_pkg::ChCntW'(fcl_pkg::MaxChannels) : fcl_pkg::ChCntW'(chans_i);

  assign last_pos = (fcl_pkg::CntW'(pos_q) + fcl_pkg::CntW'(1)) == npos;
  assign last_ch  = (fcl_pkg::ChCntW'(ch_q) + fcl_pkg::ChCntW'(1)) == nch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcl_pkg::StIdle;
      ch_q    <= '0;
      pos_q   <= '0;
      drain_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      pos_q   <= pos_d;
      drain_q <= drain_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    pos_d       = pos_q;
    drain_d     = drain_q;
    idle_o      = 1'b0;
    ctl_o       = '0;
    emit_o.emit = 1'b0;
    emit_o.ch   = ch_q;
    emit_o.last = last_ch;
    case (state_q)
      fcl_pkg::StIdle: begin
        idle_o = 1'b1;
        if (start_i && (nch != '0)) begin
          ch_d    = '0;
          state_d = fcl_pkg::StBias;
        end
      end
      fcl_pkg::StBias: begin
        ctl_o.bias_ld = 1'b1;
        pos_d         = '0;
        drain_d       = 1'b0;
        state_d       = (npos == '0) ? fcl_pkg::StDrain : fcl_pkg::StMac;
      end
      fcl_pkg::StMac: begin
        ctl_o.mac_en = 1'b1;
        if (last_pos) begin
          state_d = fcl_pkg::StDrain;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      fcl_pkg::StDrain: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = fcl_pkg::StMul;
        end
      end
      fcl_pkg::StMul: begin
        ctl_o.mul_en = 1'b1;
        state_d      = fcl_pkg::StEmit;
      end
      fcl_pkg::StEmit: begin
        if (out_free_i) begin
          emit_o.emit = 1'b1;
          if (last_ch) begin
            state_d = fcl_pkg::StIdle;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = fcl_pkg::StBias;
          end
        end
      end
      default: begin
        state_d = fcl_pkg::StIdle;
      end
    endcase
  end

  assign rd_ch_o  = ch_q;
  assign rd_pos_o = pos_q;

endmodule

`default_nettype wire

// ===== src/int8_fully_connected_layer.sv =====
// ----------------------------------------------------------------------------
// int8_fully_connected_layer
// Quantized int8 dense layer with per-channel bias and Q30 requantization.
// Loads: one transfer per cycle while idle, no result.
// Start: each channel reads 4*G positions (G = saturated group count) through
//   the single weight memory read port; results leave in channel order.
// Reset: config to group_count 1, channel_count 1, relu off; stores are
//   undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_fully_connected_layer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  fcl_req_if.sink         req_i,
  fcl_rsp_if.source       rsp_o
);

  logic [6:0]               groups_q;
  logic [6:0]               chans_q;
  logic                     relu_q;
  logic                     req_xfer;
  logic                     start;
  logic                     load;
  logic                     idle;
  logic                     out_free;
  logic [fcl_pkg::ChanW-1:0] rd_ch;
  logic [fcl_pkg::PosW-1:0]  rd_pos;
  fcl_pkg::mac_ctl_t        ctl;
  fcl_pkg::emit_t           emit;
  logic signed [7:0]        act_rd;
  logic signed [15:0]       weight_rd;
  logic signed [31:0]       bias_rd;
  logic signed [31:0]       mult_rd;
  logic signed [7:0]        value;
  logic                     out_valid_q;
  logic [5:0]               out_channel_q;
  logic signed [7:0]        out_value_q;
  logic                     out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q <= 7'd1;
      chans_q  <= 7'd1;
      relu_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (fcl_pkg::cfg_e'(cfg_idx_i))
        fcl_pkg::CfgGroups:   groups_q <= cfg_data_i;
        fcl_pkg::CfgChannels: chans_q  <= cfg_data_i;
        fcl_pkg::CfgRelu:     relu_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign req_i.ready = idle;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign start       = req_xfer && (req_i.req_type == fcl_pkg::ReqStart);
  assign load        = req_xfer && (req_i.req_type != fcl_pkg::ReqStart);
  assign out_free    = !out_valid_q || rsp_o.ready;

  fcl_store u_store (
    .clk_i    (clk_i),
    .wr_en_i  (load),
    .wr_type_i(fcl_pkg::req_e'(req_i.req_type)),
    .wr_ch_i  (req_i.channel),
    .wr_pos_i (req_i.position),
    .act_i    (req_i.activation),
    .weight_i (req_i.weight),
    .bias_i   (req_i.bias),
    .mult_i   (req_i.multiplier),
    .rd_ch_i  (rd_ch),
    .rd_pos_i (rd_pos),
    .act_o    (act_rd),
    .weight_o (weight_rd),
    .bias_o   (bias_rd),
    .mult_o   (mult_rd)
  );

  fcl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .groups_i  (groups_q),
    .chans_i   (chans_q),
    .out_free_i(out_free),
    .idle_o    (idle),
    .rd_ch_o   (rd_ch),
    .rd_pos_o  (rd_pos),
    .ctl_o     (ctl),
    .emit_o    (emit)
  );

  fcl_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .relu_i  (relu_q),
    .act_i   (act_rd),
    .weight_i(weight_rd),
    .bias_i  (bias_rd),
    .mult_i  (mult_rd),
    .value_o (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.emit) begin
      out_channel_q <= 6'(emit.ch);
      out_value_q   <= value;
      out_last_q    <= emit.last;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_channel = out_channel_q;
  assign rsp_o.out_value   = out_value_q;
  assign rsp_o.last        = out_last_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> out_free)
    else $error("result written over an untaken transfer");

  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.emit |-> !req_i.ready)
    else $error("result emitted while accepting requests");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && (chans_q != 7'd0)) |=> !req_i.ready)
    else $error("request channel still open after start");

endmodule

`default_nettype wire
